>>> src/vp2d_pkg.sv
// ----------------------------------------------------------------------------
// vp2d_pkg
// Shared types and constants for the 2-D vector projection block.
// ----------------------------------------------------------------------------
package vp2d_pkg;

	// width of each foot coordinate on the result channel
	localparam int FOOT_BITS = 19;

	// configuration port index width
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ORIGIN_X = 2'd0,
		CFG_ORIGIN_Y = 2'd1,
		CFG_BASE_X   = 2'd2,
		CFG_BASE_Y   = 2'd3
	} cfg_reg_t;

	// register values after reset
	localparam int RST_ORIGIN_X = 200;
	localparam int RST_ORIGIN_Y = 500;
	localparam int RST_BASE_X   = 500;
	localparam int RST_BASE_Y   = 500;

endpackage

>>> src/vp2d_div_cell.sv
// ----------------------------------------------------------------------------
// vp2d_div_cell
// One restoring-division cell: forms one quotient bit for both coordinates
// and hands the partial remainders to the next cell.
// ----------------------------------------------------------------------------
module vp2d_div_cell #(
	parameter int NW = 34,
	parameter int QB = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	output logic          in_rdy,
	output logic          out_vld,
	input  logic          out_rdy,
	input  logic [NW-1:0] n,
	input  logic [NW-1:0] in_mx,
	input  logic [NW-1:0] in_my,
	input  logic [QB-1:0] in_restx,
	input  logic [QB-1:0] in_resty,
	input  logic [QB-1:0] in_qx,
	input  logic [QB-1:0] in_qy,
	input  logic          in_negx,
	input  logic          in_negy,
	output logic [NW-1:0] out_mx,
	output logic [NW-1:0] out_my,
	output logic [QB-1:0] out_restx,
	output logic [QB-1:0] out_resty,
	output logic [QB-1:0] out_qx,
	output logic [QB-1:0] out_qy,
	output logic          out_negx,
	output logic          out_negy
);

	logic          vld_q;
	logic [NW-1:0] mx_q, my_q;
	logic [QB-1:0] restx_q, resty_q, qx_q, qy_q;
	logic          negx_q, negy_q;

	logic [NW:0]   tx, ty, nn;
	logic          gex, gey;
	logic [NW-1:0] nmx, nmy;

	assign in_rdy = !vld_q || out_rdy;

	// shift in the next dividend bit, subtract the divisor where it fits
	assign nn  = {1'b0, n};
	assign tx  = {in_mx, in_restx[QB-1]};
	assign ty  = {in_my, in_resty[QB-1]};
	assign gex = (tx >= nn);
	assign gey = (ty >= nn);
	assign nmx = gex ? NW'(tx - nn) : NW'(tx);
	assign nmy = gey ? NW'(ty - nn) : NW'(ty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			mx_q    <= nmx;
			my_q    <= nmy;
			restx_q <= {in_restx[QB-2:0], 1'b0};
			resty_q <= {in_resty[QB-2:0], 1'b0};
			qx_q    <= {in_qx[QB-2:0], gex};
			qy_q    <= {in_qy[QB-2:0], gey};
			negx_q  <= in_negx;
			negy_q  <= in_negy;
		end
	end

	assign out_vld   = vld_q;
	assign out_mx    = mx_q;
	assign out_my    = my_q;
	assign out_restx = restx_q;
	assign out_resty = resty_q;
	assign out_qx    = qx_q;
	assign out_qy    = qy_q;
	assign out_negx  = negx_q;
	assign out_negy  = negy_q;

endmodule

>>> src/vector_projection_2d.sv
// ----------------------------------------------------------------------------
// vector_projection_2d
// Projects a point onto the line through a configured origin and base end
// point, giving the rounded foot of the projection.
// ----------------------------------------------------------------------------
// One point is taken per clock while in_stall is low; a result passes the
// front stages (offset, products, dot product, partial products, dividend
// split), COORD_BITS+2 division cells that each form one quotient bit, one
// rounding stage and the output register. Every stage holds its own request
// and moves up into an empty slot, so new points keep entering until the
// stages fill while a result waits under stall. Configuration writes are
// always taken; the base vector and then the squared length follow a write.
// ----------------------------------------------------------------------------
module vector_projection_2d import vp2d_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [FOOT_BITS-1:0]  foot_x,
	output logic signed [FOOT_BITS-1:0]  foot_y,
	output logic                         base_degenerate
);

	localparam int C   = COORD_BITS;
	localparam int RW  = C + 1;          // offset vectors
	localparam int PRW = 2 * C + 2;      // single products
	localparam int DW  = 2 * C + 3;      // dot product, signed
	localparam int DMW = 2 * C + 2;      // dot product magnitude
	localparam int HW  = C + 1;          // half of the magnitude split
	localparam int PW  = 3 * C + 3;      // dividend
	localparam int QB  = C + 2;          // quotient bits, one per cell
	localparam int NW  = 2 * C + 2;      // squared length and remainders
	localparam int EW  = (C + 4 > FOOT_BITS) ? C + 4 : FOOT_BITS;

	localparam logic signed [C-1:0]  RST_OX = C'(RST_ORIGIN_X);
	localparam logic signed [C-1:0]  RST_OY = C'(RST_ORIGIN_Y);
	localparam logic signed [C-1:0]  RST_BX = C'(RST_BASE_X);
	localparam logic signed [C-1:0]  RST_BY = C'(RST_BASE_Y);
	localparam logic signed [RW-1:0] RST_RX = RW'(RST_BX) - RW'(RST_OX);
	localparam logic signed [RW-1:0] RST_RY = RW'(RST_BY) - RW'(RST_OY);
	localparam logic signed [NW-1:0] RST_N  = NW'(RST_RX) * NW'(RST_RX)
	                                        + NW'(RST_RY) * NW'(RST_RY);

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	logic signed [C-1:0]  origin_x_q, origin_y_q, base_x_q, base_y_q;
	logic signed [RW-1:0] rx_q, ry_q;
	logic signed [NW-1:0] sqx, sqy;
	logic [NW-1:0]        n_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= RST_OX;
			origin_y_q <= RST_OY;
			base_x_q   <= RST_BX;
			base_y_q   <= RST_BY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ORIGIN_X: origin_x_q <= cfg_data;
				CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				CFG_BASE_X:   base_x_q   <= cfg_data;
				CFG_BASE_Y:   base_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sqx = NW'(rx_q) * NW'(rx_q);
	assign sqy = NW'(ry_q) * NW'(ry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= RST_RX;
			ry_q <= RST_RY;
			n_q  <= RST_N;
		end else begin
			rx_q <= RW'(base_x_q) - RW'(origin_x_q);
			ry_q <= RW'(base_y_q) - RW'(origin_y_q);
			n_q  <= NW'(sqx + sqy);
		end
	end

	// ------------------------------------------------------------------
	// front stages: offset, products, dot product, partial products
	// ------------------------------------------------------------------
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_o;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, out_vld_q;

	logic signed [RW-1:0]  gx_s1, gy_s1;
	logic signed [PRW-1:0] px_s2, py_s2;
	logic [DMW-1:0]        dmag_s3;
	logic                  negx_s3, negy_s3;
	logic [PRW-1:0]        ppxl_s4, ppxh_s4, ppyl_s4, ppyh_s4;
	logic                  negx_s4, negy_s4;
	logic [NW-1:0]         mx_s5, my_s5;
	logic [QB-1:0]         restx_s5, resty_s5;
	logic                  negx_s5, negy_s5;

	logic signed [DW-1:0]  dsum;
	logic                  dneg;
	logic [DMW-1:0]        dmag;
	logic [RW-1:0]         arx, ary;
	logic [PW-1:0]         bigx, bigy;

	logic                  c_vld [0:QB];
	logic                  c_rdy [0:QB];

	assign adv_s1   = !vld_s1 || adv_s2;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s5   = !vld_s5 || c_rdy[0];
	assign adv_s6   = !vld_s6 || adv_o;
	assign adv_o    = !out_vld_q || !out_stall;
	assign in_stall = !adv_s1;

	assign dsum = DW'(px_s2) + DW'(py_s2);
	assign dneg = dsum[DW-1];
	assign dmag = dneg ? DMW'(-dsum) : DMW'(dsum);
	assign arx  = rx_q[RW-1] ? RW'(-rx_q) : RW'(rx_q);
	assign ary  = ry_q[RW-1] ? RW'(-ry_q) : RW'(ry_q);
	assign bigx = {ppxh_s4, {HW{1'b0}}} + PW'(ppxl_s4);
	assign bigy = {ppyh_s4, {HW{1'b0}}} + PW'(ppyl_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			gx_s1 <= RW'(point_x) - RW'(origin_x_q);
			gy_s1 <= RW'(point_y) - RW'(origin_y_q);
		end
		if (adv_s2 && vld_s1) begin
			px_s2 <= PRW'(gx_s1) * PRW'(rx_q);
			py_s2 <= PRW'(gy_s1) * PRW'(ry_q);
		end
		if (adv_s3 && vld_s2) begin
			dmag_s3 <= dmag;
			negx_s3 <= rx_q[RW-1] ^ dneg;
			negy_s3 <= ry_q[RW-1] ^ dneg;
		end
		if (adv_s4 && vld_s3) begin
			ppxl_s4 <= PRW'(arx) * PRW'(dmag_s3[HW-1:0]);
			ppxh_s4 <= PRW'(arx) * PRW'(dmag_s3[DMW-1:HW]);
			ppyl_s4 <= PRW'(ary) * PRW'(dmag_s3[HW-1:0]);
			ppyh_s4 <= PRW'(ary) * PRW'(dmag_s3[DMW-1:HW]);
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
		end
		if (adv_s5 && vld_s4) begin
			// upper dividend bits start as the remainder, lower bits shift in
			mx_s5    <= NW'(bigx >> QB);
			my_s5    <= NW'(bigy >> QB);
			restx_s5 <= bigx[QB-1:0];
			resty_s5 <= bigy[QB-1:0];
			negx_s5  <= negx_s4;
			negy_s5  <= negy_s4;
		end
	end

	// ------------------------------------------------------------------
	// division chain: one quotient bit per cell
	// ------------------------------------------------------------------
	logic [NW-1:0] c_mx    [0:QB];
	logic [NW-1:0] c_my    [0:QB];
	logic [QB-1:0] c_restx [0:QB];
	logic [QB-1:0] c_resty [0:QB];
	logic [QB-1:0] c_qx    [0:QB];
	logic [QB-1:0] c_qy    [0:QB];
	logic          c_negx  [0:QB];
	logic          c_negy  [0:QB];

	assign c_vld[0]   = vld_s5;
	assign c_mx[0]    = mx_s5;
	assign c_my[0]    = my_s5;
	assign c_restx[0] = restx_s5;
	assign c_resty[0] = resty_s5;
	assign c_qx[0]    = '0;
	assign c_qy[0]    = '0;
	assign c_negx[0]  = negx_s5;
	assign c_negy[0]  = negy_s5;
	assign c_rdy[QB]  = adv_s6;

	for (genvar i = 0; i < QB; i++) begin : g_cell
		vp2d_div_cell #(
			.NW (NW),
			.QB (QB)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_vld    (c_vld[i]),
			.in_rdy    (c_rdy[i]),
			.out_vld   (c_vld[i+1]),
			.out_rdy   (c_rdy[i+1]),
			.n         (n_q),
			.in_mx     (c_mx[i]),
			.in_my     (c_my[i]),
			.in_restx  (c_restx[i]),
			.in_resty  (c_resty[i]),
			.in_qx     (c_qx[i]),
			.in_qy     (c_qy[i]),
			.in_negx   (c_negx[i]),
			.in_negy   (c_negy[i]),
			.out_mx    (c_mx[i+1]),
			.out_my    (c_my[i+1]),
			.out_restx (c_restx[i+1]),
			.out_resty (c_resty[i+1]),
			.out_qx    (c_qx[i+1]),
			.out_qy    (c_qy[i+1]),
			.out_negx  (c_negx[i+1]),
			.out_negy  (c_negy[i+1])
		);
	end

	// ------------------------------------------------------------------
	// rounding and output register
	// ------------------------------------------------------------------
	logic [QB-1:0]        qrx_s6, qry_s6;
	logic                 negx_s6, negy_s6;
	logic                 incx, incy;
	logic signed [EW-1:0] ox_e, oy_e, qx_e, qy_e, sx, sy;
	logic                 degen;
	logic signed [FOOT_BITS-1:0] foot_x_q, foot_y_q;
	logic                 degen_q;

	// round half away from zero: bump when twice the remainder reaches n
	assign incx = ({c_mx[QB], 1'b0} >= {1'b0, n_q});
	assign incy = ({c_my[QB], 1'b0} >= {1'b0, n_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv_s6) vld_s6 <= c_vld[QB];
			if (adv_o)  out_vld_q <= vld_s6;
		end
	end

	assign ox_e  = EW'(origin_x_q);
	assign oy_e  = EW'(origin_y_q);
	assign qx_e  = EW'(qrx_s6);
	assign qy_e  = EW'(qry_s6);
	assign sx    = negx_s6 ? ox_e - qx_e : ox_e + qx_e;
	assign sy    = negy_s6 ? oy_e - qy_e : oy_e + qy_e;
	assign degen = (n_q == '0);

	always_ff @(posedge clk) begin
		if (adv_s6 && c_vld[QB]) begin
			qrx_s6  <= c_qx[QB] + QB'(incx);
			qry_s6  <= c_qy[QB] + QB'(incy);
			negx_s6 <= c_negx[QB];
			negy_s6 <= c_negy[QB];
		end
		if (adv_o && vld_s6) begin
			// zero-length base: report the origin itself
			foot_x_q <= degen ? ox_e[FOOT_BITS-1:0] : sx[FOOT_BITS-1:0];
			foot_y_q <= degen ? oy_e[FOOT_BITS-1:0] : sy[FOOT_BITS-1:0];
			degen_q  <= degen;
		end
	end

	assign out_valid       = out_vld_q;
	assign foot_x          = foot_x_q;
	assign foot_y          = foot_y_q;
	assign base_degenerate = degen_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled although the output register is empty");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s2) |=> vld_s1)
		else $error("first stage dropped a blocked request");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && adv_o) |=> out_valid)
		else $error("rounded result did not reach the output register");

endmodule
